/* rtl/ists_pkg.sv */
// Shared types and constants for the indexed sequence store.
// No dependencies; imported by ists_cell and indexed_sequence_store_core.
package ists_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = 5;
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_AT   = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_AT   = 3'd5,
    OP_DISPLAY  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    op_t                     operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] entry_value;
    logic [CNT_W-1:0]        entry_count;
    logic                    last;
  } out_req_t;

  // Broadcast command to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [IDX_W-1:0] pos;
  } cell_cmd_t;

endpackage

/* rtl/ists_cell.sv */
// One storage cell of the sequence chain: holds one entry and moves it
// to or from its neighbors per the broadcast command. Uses ists_pkg.
module ists_cell (
  input  logic                             clk,
  input  logic [ists_pkg::IDX_W-1:0]       idx,
  input  ists_pkg::cell_cmd_t              cmd,
  input  logic signed [ists_pkg::VAL_W-1:0] ins_value,
  input  logic signed [ists_pkg::VAL_W-1:0] head_value,
  input  logic signed [ists_pkg::VAL_W-1:0] left_in,
  input  logic signed [ists_pkg::VAL_W-1:0] right_in,
  output logic signed [ists_pkg::VAL_W-1:0] value_out
);
  import ists_pkg::*;

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_INS: begin
        if (idx > cmd.pos) data_nxt = left_in;
        else if (idx == cmd.pos) data_nxt = ins_value;
      end
      CELL_DEL: begin
        if (idx >= cmd.pos) data_nxt = right_in;
      end
      CELL_ROT: begin
        // tail slot takes the head, everyone else moves one toward the head
        if (idx == cmd.pos) data_nxt = head_value;
        else data_nxt = right_in;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign value_out = data_r;

endmodule

/* rtl/indexed_sequence_store_core.sv */
// Top level of the indexed sequence store: control, status, output register
// and the chain of ists_cell entries. Uses ists_pkg.
//
// Holds an ordered list of up to CAPACITY (16) signed 32-bit entries in a
// row of cells, head in cell 0. Insert and delete requests are accepted one
// per cycle while idle and the output register is free: every cell compares
// its own index with the broadcast position and shifts toward or away from
// the head in the same edge, and an update yields one result request with
// status and new count. Display walks the list by rotating the chain one step
// per delivered result (an empty list gives one empty result); the input
// stays stalled until the last entry has been loaded into the output
// register. The output register lets a new request in while the previous
// result still waits, as long as out_stall is low.
module indexed_sequence_store_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ists_pkg::in_req_t in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ists_pkg::out_req_t out_data
);
  import ists_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DISPLAY
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] disp_idx_r, disp_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_req_t         out_data_r, out_data_nxt;

  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] cell_q [CAPACITY];

  logic             out_free;
  logic             in_accept;
  logic             is_full;
  logic             is_empty;
  logic [CNT_W-1:0] tgt;
  logic [CNT_W-1:0] occ_m1;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_accept = in_valid && !in_stall;
  assign is_full   = (occ_r == CNT_W'(CAPACITY));
  assign is_empty  = (occ_r == '0);
  assign occ_m1    = occ_r - CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    disp_idx_nxt  = disp_idx_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = CELL_HOLD;
    cmd.pos       = '0;
    tgt           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.entry_value = '0;
          out_data_nxt.last        = 1'b1;
          out_data_nxt.status      = ST_OK;
          unique case (in_data.operation)
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
              if (in_data.operation == OP_INS_HEAD) tgt = '0;
              else if (in_data.operation == OP_INS_TAIL) tgt = occ_r;
              else tgt = in_data.position;
              // full check wins over the position check
              if (is_full) out_data_nxt.status = ST_FULL;
              else if (tgt > occ_r) out_data_nxt.status = ST_BAD_INDEX;
              else begin
                cmd.op  = CELL_INS;
                cmd.pos = tgt[IDX_W-1:0];
                occ_nxt = occ_r + CNT_W'(1);
              end
            end
            OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT: begin
              if (in_data.operation == OP_DEL_HEAD) tgt = '0;
              else if (in_data.operation == OP_DEL_TAIL) tgt = occ_m1;
              else tgt = in_data.position;
              if (is_empty) out_data_nxt.status = ST_EMPTY;
              else if (tgt >= occ_r) out_data_nxt.status = ST_BAD_INDEX;
              else begin
                cmd.op  = CELL_DEL;
                cmd.pos = tgt[IDX_W-1:0];
                occ_nxt = occ_m1;
              end
            end
            OP_DISPLAY: begin
              if (is_empty) begin
                out_data_nxt.status = ST_EMPTY;
              end else begin
                // results come from the walk; nothing loaded yet
                out_valid_nxt = out_valid_r && out_stall;
                disp_idx_nxt  = '0;
                state_nxt     = S_DISPLAY;
              end
            end
            default: out_data_nxt.status = ST_BAD_INDEX;
          endcase
          out_data_nxt.entry_count = occ_nxt;
        end
      end
      S_DISPLAY: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = ST_OK;
          out_data_nxt.entry_value = cell_q[0];
          out_data_nxt.entry_count = occ_r;
          out_data_nxt.last        = (disp_idx_r == occ_m1);
          // rotate so the next entry sits at the head; after occ_r steps
          // the list is back in its original order
          cmd.op       = CELL_ROT;
          cmd.pos      = occ_m1[IDX_W-1:0];
          disp_idx_nxt = disp_idx_r + CNT_W'(1);
          if (disp_idx_r == occ_m1) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      disp_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      disp_idx_r  <= disp_idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // cell chain
  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VAL_W-1:0] left_in;
      logic signed [VAL_W-1:0] right_in;
      if (g == 0) begin : g_head
        assign left_in = '0;
      end else begin : g_mid_l
        assign left_in = cell_q[g-1];
      end
      if (g == CAPACITY - 1) begin : g_tail
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cell_q[g+1];
      end
      ists_cell u_cell (
        .clk        (clk),
        .idx        (IDX_W'(g)),
        .cmd        (cmd),
        .ins_value  (in_data.value),
        .head_value (cell_q[0]),
        .left_in    (left_in),
        .right_in   (right_in),
        .value_out  (cell_q[g])
      );
    end
  endgenerate

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count never passes capacity
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // an update request yields a final result on the next cycle
  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_data.operation != OP_DISPLAY) |=> (out_valid_r && out_data_r.last))
    else $error("update request without result");

  // a pending result always reports the current count
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.entry_count == occ_r))
    else $error("result count differs from occupancy");

  // the walk never changes the list length
  a_display_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISPLAY) |=> $stable(occ_r))
    else $error("occupancy changed during display");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for indexed_sequence_store_core: directed table, then random traffic.
// Depends on ists_pkg and the RTL of the store only; carries its own list predictor and scoreboard.
// Both handshakes are valid/stall, with random bursts, gaps and back-pressure.
module testbench;
  import ists_pkg::*;

  localparam int RANDOM_ITEMS     = 64;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int DRAIN_GUARD      = 20000;
  localparam int DIRECTED_ROWS    = 27;

  // Operation code that the package leaves unnamed; the block must answer it with a bad index.
  localparam logic [2:0] OP_UNUSED = 3'd7;

  localparam logic signed [VAL_W-1:0] VALUE_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VALUE_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_data;

  always #1 clk = ~clk;

  indexed_sequence_store_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // ---------------------------------------------------------------------------
  // List predictor: its own copy of the cells and the occupancy.
  // ---------------------------------------------------------------------------
  logic signed [VAL_W-1:0] model_cells [CAPACITY];
  int       model_count = 0;
  out_req_t step_results [$];      // results caused by the request just applied
  out_req_t expected_results [$];  // results still owed by the block, oldest first
  int       mismatches = 0;

  function automatic out_req_t make_result(status_t st, logic signed [VAL_W-1:0] v, logic last);
    out_req_t res;
    res.status      = st;
    res.entry_value = v;
    res.entry_count = CNT_W'(model_count);
    res.last        = last;
    return res;
  endfunction

  // Full is checked before the position; position == count appends.
  function automatic status_t model_insert(int pos, logic signed [VAL_W-1:0] v);
    if (model_count >= CAPACITY) return ST_FULL;
    if (pos > model_count) return ST_BAD_INDEX;
    for (int i = model_count; i > pos; i--) model_cells[i] = model_cells[i-1];
    model_cells[pos] = v;
    model_count++;
    return ST_OK;
  endfunction

  // Empty is checked before the position.
  function automatic status_t model_delete(int pos);
    if (model_count == 0) return ST_EMPTY;
    if (pos >= model_count) return ST_BAD_INDEX;
    for (int i = pos; i + 1 < model_count; i++) model_cells[i] = model_cells[i+1];
    model_count--;
    return ST_OK;
  endfunction

  function automatic void model_list_op(in_req_t req);
    status_t st;
    step_results.delete();
    case (req.operation)
      OP_INS_HEAD: st = model_insert(0, req.value);
      OP_INS_TAIL: st = model_insert(model_count, req.value);
      OP_INS_AT:   st = model_insert(int'(req.position), req.value);
      OP_DEL_HEAD: st = model_delete(0);
      OP_DEL_TAIL: st = (model_count == 0) ? ST_EMPTY : model_delete(model_count - 1);
      OP_DEL_AT:   st = model_delete(int'(req.position));
      OP_DISPLAY: begin
        // one result per entry, head first; empty list gives a single empty result
        if (model_count == 0) step_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
        for (int i = 0; i < model_count; i++)
          step_results.push_back(make_result(ST_OK, model_cells[i], i + 1 == model_count));
        return;
      end
      default:     st = ST_BAD_INDEX;
    endcase
    step_results.push_back(make_result(st, '0, 1'b1));
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  // Offers one request, waits for the handshake, then records what it owes.
  // A typed row replaces the predicted result with the value written in the table.
  task automatic offer_request(input in_req_t req, input bit typed, input out_req_t golden);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      in_data  <= '{operation: op_t'($urandom_range(0, 7)), position: POS_W'($urandom),
                    value: $urandom};
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    model_list_op(req);
    if (typed) begin
      expected_results.push_back(golden);
    end else begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
  endtask

  // Sender goes quiet until the block has delivered everything it owes.
  task automatic drain_wait();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Random traffic follows the fill level: it leans toward inserts while filling and
  // toward deletes while emptying, so full and empty are both reached repeatedly.
  bit filling_up = 1'b1;

  function automatic in_req_t random_list_request();
    in_req_t req;
    int      pick;
    int      insert_share;
    pick         = $urandom_range(0, 99);
    insert_share = filling_up ? 65 : 25;
    req.position = POS_W'($urandom);
    req.value    = $urandom;
    if ($urandom_range(0, 9) == 0) req.value = ($urandom_range(0, 1) == 1) ? VALUE_MIN : VALUE_MAX;
    if (pick < 3) begin
      req.operation = op_t'(OP_UNUSED);
    end else if (pick < 13) begin
      req.operation = OP_DISPLAY;
    end else if (pick < 13 + insert_share) begin
      case ($urandom_range(0, 2))
        0: req.operation = OP_INS_HEAD;
        1: req.operation = OP_INS_TAIL;
        default: begin
          req.operation = OP_INS_AT;
          // mostly a legal slot, sometimes anything the field holds
          if ($urandom_range(0, 4) != 0) req.position = POS_W'($urandom_range(0, model_count));
        end
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0: req.operation = OP_DEL_HEAD;
        1: req.operation = OP_DEL_TAIL;
        default: begin
          req.operation = OP_DEL_AT;
          if (model_count > 0 && $urandom_range(0, 4) != 0)
            req.position = POS_W'($urandom_range(0, model_count - 1));
        end
      endcase
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table. Rows with typed set carry their single result inline
  // (entry_value 0, last 1); the others are checked against the predictor.
  // reps repeats a row with value stepping by one.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [2:0]       op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
    logic [4:0]       reps;
    logic             typed;
    status_t          st;
    logic [CNT_W-1:0] cnt;
  } directed_row_t;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // empty store: display, every delete, a bad insert slot and an unused code
    '{OP_DISPLAY,  5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     5'd0},
    '{OP_DEL_HEAD, 5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     5'd0},
    '{OP_DEL_TAIL, 5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     5'd0},
    '{OP_DEL_AT,   5'd31, 32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     5'd0},
    '{OP_INS_AT,   5'd1,  32'h0000_0005, 5'd1,  1'b1, ST_BAD_INDEX, 5'd0},
    '{OP_UNUSED,   5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_BAD_INDEX, 5'd0},
    // value extremes, middle insert and append at position == count
    '{OP_INS_HEAD, 5'd0,  32'h8000_0000, 5'd1,  1'b1, ST_OK,        5'd1},
    '{OP_INS_TAIL, 5'd31, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,        5'd2},
    '{OP_INS_AT,   5'd1,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_OK,        5'd3},
    '{OP_INS_AT,   5'd3,  32'h0000_0000, 5'd1,  1'b1, ST_OK,        5'd4},
    '{OP_DISPLAY,  5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,        5'd0},
    // positions at and past the count
    '{OP_DEL_AT,   5'd4,  32'h0000_0000, 5'd1,  1'b1, ST_BAD_INDEX, 5'd4},
    '{OP_DEL_AT,   5'd31, 32'h0000_0000, 5'd1,  1'b1, ST_BAD_INDEX, 5'd4},
    '{OP_INS_AT,   5'd5,  32'h0000_0001, 5'd1,  1'b1, ST_BAD_INDEX, 5'd4},
    '{OP_DEL_AT,   5'd1,  32'h0000_0000, 5'd1,  1'b1, ST_OK,        5'd3},
    '{OP_DEL_HEAD, 5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,        5'd2},
    '{OP_DEL_TAIL, 5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_OK,        5'd1},
    '{OP_DISPLAY,  5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,        5'd0},
    // fill to capacity through the middle, then hit full from every insert
    '{OP_INS_AT,   5'd1,  32'h0000_1000, 5'd15, 1'b0, ST_OK,        5'd0},
    '{OP_INS_HEAD, 5'd0,  32'h5555_5555, 5'd1,  1'b1, ST_FULL,      5'd16},
    '{OP_INS_AT,   5'd31, 32'hAAAA_AAAA, 5'd1,  1'b1, ST_FULL,      5'd16},
    '{OP_INS_TAIL, 5'd0,  32'h0000_0007, 5'd1,  1'b1, ST_FULL,      5'd16},
    '{OP_DISPLAY,  5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,        5'd0},
    '{OP_DEL_AT,   5'd16, 32'h0000_0000, 5'd1,  1'b1, ST_BAD_INDEX, 5'd16},
    '{OP_DEL_AT,   5'd15, 32'h0000_0000, 5'd1,  1'b1, ST_OK,        5'd15},
    // empty it again and show the empty display once more
    '{OP_DEL_TAIL, 5'd0,  32'h0000_0000, 5'd15, 1'b0, ST_OK,        5'd0},
    '{OP_DISPLAY,  5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     5'd0}
  };

  // ---------------------------------------------------------------------------
  // Result side: stall pattern of its own, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  bit hold_off_req = 1'b0;

  initial begin : result_backpressure
    int mode;
    int run_left;
    int tick;
    mode     = 0;
    run_left = 0;
    tick     = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // long hold: the block fills up and must stall its input
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      if (run_left == 0) begin
        mode     = $urandom_range(0, 3);
        run_left = $urandom_range(8, 48);
      end
      run_left--;
      tick++;
      case (mode)
        0:       out_stall <= 1'b0;                          // free-flowing stretch
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= (tick % 5 < 2);                // two of every five
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // Scoreboard: every delivered result against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d value %0d count %0d last %0d",
               out_data.status, out_data.entry_value, out_data.entry_count, out_data.last);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.entry_value !== want.entry_value) begin
          $error("entry_value: expected %0d, got %0d", want.entry_value, out_data.entry_value);
          mismatches++;
        end
        if (out_data.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, out_data.entry_count);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    directed_row_t row;
    in_req_t       req;
    out_req_t      golden;
    int            guard;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int k = 0; k < int'(row.reps); k++) begin
        req.operation      = op_t'(row.op);
        req.position       = row.pos;
        req.value          = row.value + k;
        golden.status      = row.st;
        golden.entry_value = '0;
        golden.entry_count = row.cnt;
        golden.last        = 1'b1;
        offer_request(req, row.typed, golden);
      end
    end

    // settle, then start the random part under a long receiver hold-off
    drain_wait();
    hold_off_req = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_wait();
      offer_request(random_list_request(), 1'b0, '0);
      if (model_count == CAPACITY) filling_up = 1'b0;
      else if (model_count == 0) filling_up = 1'b1;
      else if ($urandom_range(0, 19) == 0) filling_up = !filling_up;
    end
    in_valid <= 1'b0;

    guard = 0;
    while (expected_results.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    // room for any stray result after the last one owed
    repeat (CAPACITY + 8) @(posedge clk);

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ists_pkg.sv
rtl/ists_cell.sv
rtl/indexed_sequence_store_core.sv
tb/testbench.sv
